>>> rtl/mlpa_pkg.sv
package mlpa_pkg;

   localparam int SumBits   = 40;
   localparam int QuotBits  = 40;
   localparam int DivBits   = 8;
   localparam int FracBits  = 8;
   localparam int MaxLooks  = 16;

   typedef struct packed {
      logic [15:0] amplitude;
      logic        line_end;
   } req_type;

   typedef struct packed {
      logic [39:0] mean_power;
      logic [9:0]  out_col;
      logic        last_in_row;
   } rsp_type;

   typedef enum logic [1:0] {
      REG_LOOK_COLS  = 2'd0,
      REG_LOOK_ROWS  = 2'd1,
      REG_COL_OFFSET = 2'd2,
      REG_OUT_COLS   = 2'd3
   } reg_index_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture accepted sample and update counters
      logic div_start;  // start the divider on the captured sum
      logic div_step;   // one restoring-division step
      logic rsp_load;   // move the quotient to the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;       // the captured sample completes a box
      logic div_done;   // last division step under way
   } status_type;

endpackage

>>> rtl/mlpa_ctrl.sv
module mlpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mlpa_pkg::status_type   status,
   output mlpa_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ACCUM  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_OUTPUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;
   // the output register frees while the next item is at work
   assign req_ready = (state_ff == ST_IDLE);

   // sequence: accept, accumulate; on box end divide, output
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (status.emit) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/mlpa_datapath.sv
module mlpa_datapath #(
   parameter int MAX_OUT_COLS = 1024,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mlpa_pkg::req_type    req_data,
   input  logic [4:0]           look_cols,
   input  logic [4:0]           look_rows,
   input  logic [15:0]          col_offset,
   input  logic [10:0]          out_cols,
   input  mlpa_pkg::cmd_type    cmd,
   output mlpa_pkg::status_type status,
   output mlpa_pkg::rsp_type    rsp_data
);

   localparam int IdxBits  = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
   localparam int LookBits = (mlpa_pkg::MaxLooks > 1) ? $clog2(mlpa_pkg::MaxLooks) : 1;
   localparam int SqBits   = 2 * SAMPLE_BITS;
   localparam int StepBits = $clog2(mlpa_pkg::QuotBits + 1);
   localparam int DivW     = mlpa_pkg::DivBits + 1;

   logic [mlpa_pkg::SumBits-1:0] sums_mem [MAX_OUT_COLS];

   logic [15:0]         in_col_ff, in_col_in;
   logic [LookBits-1:0] sub_col_ff, sub_col_in;
   logic [16:0]         out_col_ff, out_col_in;
   logic [LookBits-1:0] look_row_ff, look_row_in;
   logic                done_ff, done_in;

   // sample stage
   logic [SqBits-1:0]  sq_ff;
   logic               use_ff, fresh_ff, emit_ff, last_ff;
   logic [IdxBits-1:0] idx_ff;
   logic [16:0]        ocol_ff;
   logic [DivW-1:0]    div_ff;

   logic [mlpa_pkg::SumBits-1:0]  rd_ff, sum_new;
   logic [mlpa_pkg::QuotBits-1:0] quo_ff;
   logic [DivW:0]                 rem_ff;
   logic [mlpa_pkg::SumBits+mlpa_pkg::FracBits-1:0] num_ff;
   logic [StepBits-1:0]           step_ff;
   mlpa_pkg::rsp_type             rsp_ff;

   logic [LookBits:0] lc, lr;
   logic [16:0]       oc;
   logic              active, last_row, grp_end, win_end;

   // clamp configuration into its working range
   always_comb begin
      lc = (look_cols == 5'd0) ? (LookBits+1)'(1) :
           ((32'(look_cols) > mlpa_pkg::MaxLooks) ? (LookBits+1)'(mlpa_pkg::MaxLooks)
                                                  : (LookBits+1)'(look_cols));
      lr = (look_rows == 5'd0) ? (LookBits+1)'(1) :
           ((32'(look_rows) > mlpa_pkg::MaxLooks) ? (LookBits+1)'(mlpa_pkg::MaxLooks)
                                                  : (LookBits+1)'(look_rows));
      oc = (out_cols == 11'd0) ? 17'd1 :
           ((32'(out_cols) > MAX_OUT_COLS) ? 17'(MAX_OUT_COLS) : 17'(out_cols));
   end

   // window and box position of the arriving sample
   always_comb begin
      active   = (in_col_ff >= col_offset) && !done_ff;
      last_row = (32'(look_row_ff) + 1) >= 32'(lr);
      grp_end  = (32'(sub_col_ff) + 1) >= 32'(lc);
      win_end  = (32'(out_col_ff) + 1) >= 32'(oc);
      in_col_in   = (in_col_ff != 16'hFFFF) ? in_col_ff + 16'd1 : in_col_ff;
      sub_col_in  = sub_col_ff;
      out_col_in  = out_col_ff;
      done_in     = done_ff;
      look_row_in = look_row_ff;
      if (active) begin
         if (grp_end) begin
            sub_col_in = '0;
            if (win_end) done_in = 1'b1;
            else out_col_in = out_col_ff + 17'd1;
         end else begin
            sub_col_in = sub_col_ff + LookBits'(1);
         end
      end
      if (req_data.line_end) begin
         in_col_in   = '0;
         sub_col_in  = '0;
         out_col_in  = '0;
         done_in     = 1'b0;
         look_row_in = last_row ? '0 : look_row_ff + LookBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         sub_col_ff  <= '0;
         out_col_ff  <= '0;
         look_row_ff <= '0;
         done_ff     <= 1'b0;
         use_ff      <= 1'b0;
         emit_ff     <= 1'b0;
      end else if (cmd.load) begin
         in_col_ff   <= in_col_in;
         sub_col_ff  <= sub_col_in;
         out_col_ff  <= out_col_in;
         look_row_ff <= look_row_in;
         done_ff     <= done_in;
         use_ff      <= active;
         emit_ff     <= active && grp_end && last_row;
      end
   end

   // capture square and read the accumulator
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sq_ff    <= SqBits'(req_data.amplitude[SAMPLE_BITS-1:0])
                     * SqBits'(req_data.amplitude[SAMPLE_BITS-1:0]);
         fresh_ff <= (look_row_ff == '0) && (sub_col_ff == '0);
         idx_ff   <= out_col_ff[IdxBits-1:0];
         ocol_ff  <= out_col_ff;
         last_ff  <= win_end;
         div_ff   <= DivW'(lr) * DivW'(lc);
         rd_ff    <= sums_mem[out_col_ff[IdxBits-1:0]];
      end
   end

   assign sum_new = fresh_ff ? mlpa_pkg::SumBits'(sq_ff)
                             : rd_ff + mlpa_pkg::SumBits'(sq_ff);

   always_ff @(posedge clock) begin
      if (use_ff && !cmd.load && !cmd.div_step && !cmd.rsp_load && step_ff == '0)
         sums_mem[idx_ff] <= sum_new;
   end

   // restoring division, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load) begin
         step_ff <= '0;
      end else if (cmd.div_start) begin
         num_ff  <= {sum_new, mlpa_pkg::FracBits'(0)};
         rem_ff  <= '0;
         quo_ff  <= '0;
         step_ff <= StepBits'(mlpa_pkg::SumBits + mlpa_pkg::FracBits);
      end else if (cmd.div_step && step_ff != '0) begin
         logic [DivW+1:0] trial;
         trial   = {rem_ff, num_ff[$high(num_ff)]} - {2'b0, div_ff};
         num_ff  <= num_ff << 1;
         if (!trial[DivW+1]) rem_ff <= trial[DivW:0];
         else rem_ff <= {rem_ff[DivW-1:0], num_ff[$high(num_ff)]};
         quo_ff  <= {quo_ff[mlpa_pkg::QuotBits-2:0], !trial[DivW+1]};
         step_ff <= step_ff - StepBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.mean_power  <= quo_ff;
         rsp_ff.out_col     <= ocol_ff[9:0];
         rsp_ff.last_in_row <= last_ff;
      end
   end

   assign status.emit     = emit_ff;
   assign status.div_done = (step_ff == StepBits'(1));
   assign rsp_data        = rsp_ff;

endmodule

>>> rtl/multilook_power_average.sv
// Multilook power averaging. Amplitude samples stream in raster order; each
// one is accepted and its accumulator entry read, modified and written
// before the next sample is accepted. A sample that completes a box then
// runs the bit-serial divider (one quotient bit per cycle over the 40-bit sum
// with 8 fraction bits) and loads the output register, and waits longer
// while the previous result is still held there. The per-column sum store
// is an on-chip memory written at one address per item.
module multilook_power_average #(
   parameter int MAX_OUT_COLS = 1024,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mlpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mlpa_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [4:0]  look_cols_ff, look_rows_ff;
   logic [15:0] col_offset_ff;
   logic [10:0] out_cols_ff;
   mlpa_pkg::cmd_type    cmd;
   mlpa_pkg::status_type status;
   mlpa_pkg::reg_index_type reg_sel;
   logic wr;

   assign csr_pready = 1'b1;
   assign reg_sel    = mlpa_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         look_cols_ff  <= 5'd1;
         look_rows_ff  <= 5'd1;
         col_offset_ff <= 16'd0;
         out_cols_ff   <= 11'd1024;
      end else if (wr) begin
         unique case (reg_sel)
            mlpa_pkg::REG_LOOK_COLS:  look_cols_ff  <= csr_pwdata[4:0];
            mlpa_pkg::REG_LOOK_ROWS:  look_rows_ff  <= csr_pwdata[4:0];
            mlpa_pkg::REG_COL_OFFSET: col_offset_ff <= csr_pwdata[15:0];
            mlpa_pkg::REG_OUT_COLS:   out_cols_ff   <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_sel)
         mlpa_pkg::REG_LOOK_COLS:  csr_prdata = {27'd0, look_cols_ff};
         mlpa_pkg::REG_LOOK_ROWS:  csr_prdata = {27'd0, look_rows_ff};
         mlpa_pkg::REG_COL_OFFSET: csr_prdata = {16'd0, col_offset_ff};
         mlpa_pkg::REG_OUT_COLS:   csr_prdata = {21'd0, out_cols_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   mlpa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   mlpa_datapath #(
      .MAX_OUT_COLS(MAX_OUT_COLS), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock, .reset, .req_data,
      .look_cols(look_cols_ff), .look_rows(look_rows_ff),
      .col_offset(col_offset_ff), .out_cols(out_cols_ff),
      .cmd, .status, .rsp_data
   );

endmodule

>>> rtl/mlpa_checker.sv
module mlpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mlpa_pkg::rsp_type rsp_data,
   input logic              csr_pready
);

   // a result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // no new item accepted in the cycle after one is accepted
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted back to back");

   // a result appears only when the input was blocked just before it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result without work");

   assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind multilook_power_average mlpa_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_data, .csr_pready
);
